// ===== src/plg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plg_pkg: shared types and constants of the polyline length block
// Holds the field widths, the derived datapath widths, the controller state
// encoding and the command and status bundles between controller and datapath.
// ============================================================================
package plg_pkg;

    // Coordinate width of one vertex field (two's complement, Q12.4).
    localparam int COORD_BITS = 16;

    // Result field widths.
    localparam int LEN_W   = 32;
    localparam int COUNT_W = 16;

    // Absolute coordinate difference, its square, the square root radicand
    // (kept even so that it splits into bit pairs) and the root.
    localparam int DIFF_W  = COORD_BITS;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int RAD_W   = 2 * DIFF_W + 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int STEP_W  = $clog2(ROOT_W);

    // Stream packing.
    localparam int IN_TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LEN_W + 1 + COUNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_ROOT,
        ST_ACC,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;        // take the vertex and its differences
        logic square_x;       // register dx squared
        logic square_y;       // register dy squared
        logic load_radicand;  // form the sum of squares, clear the root
        logic root_step;      // one digit of the square root
        logic accumulate;     // add the segment length, saturating
        logic finish;         // update vertex state or emit the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_vertex;   // no vertex of the current polyline seen yet
        logic last_vertex;    // captured vertex closes the polyline
    } t_dp_sts;

endpackage

// ===== src/plg_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plg_ctrl: sequencing controller
// Walks every later vertex through squaring, the digit-serial square root
// and the accumulation, and owns the valid flag of the result register.
// ============================================================================
module plg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output plg_pkg::t_dp_cmd  o_cmd,
    input  plg_pkg::t_dp_sts  i_sts
);
    import plg_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_sts.first_vertex ? ST_FIN : ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                o_cmd.square_x = 1'b1;
                n_state        = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                o_cmd.square_y = 1'b1;
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.load_radicand = 1'b1;
                n_step              = '0;
                n_state             = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_ACC;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state          = ST_FIN;
            end
            ST_FIN: begin
                // A closing vertex waits here only while the previous result
                // still sits unclaimed in the output register.
                if (!i_sts.last_vertex || !r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                    if (i_sts.last_vertex) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/plg_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plg_datapath: difference, squaring, square root and accumulation
// Holds the polyline state, one shared multiplier, the restoring square root
// that yields one root bit per step, and the result register.
// ============================================================================
module plg_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  plg_pkg::t_dp_cmd             i_cmd,
    output plg_pkg::t_dp_sts             o_sts,
    input  plg_pkg::t_coord              i_point_x,
    input  plg_pkg::t_coord              i_point_y,
    input  logic                         i_last_vertex,
    output logic [plg_pkg::LEN_W-1:0]    o_total_length,
    output logic                         o_is_closed,
    output logic [plg_pkg::COUNT_W-1:0]  o_vertex_count,
    output logic                         o_length_saturated
);
    import plg_pkg::*;

    // Polyline state.
    t_coord              r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [LEN_W-1:0]    r_len;
    logic [COUNT_W-1:0]  r_count;
    logic                r_sat;

    // Working registers of the current vertex.
    t_coord              r_x, r_y;
    logic                r_last;
    logic [DIFF_W-1:0]   r_dx, r_dy;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y;
    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;

    // Result register.
    logic [LEN_W-1:0]    r_out_len;
    logic                r_out_closed;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_sat;

    logic signed [DIFF_W:0] w_dx, w_dy;
    logic [DIFF_W-1:0]      w_abs_dx, w_abs_dy;
    logic [DIFF_W-1:0]      w_mul_a;
    logic [SQ_W-1:0]        w_mul_p;
    logic [REM_W-1:0]       w_rem_sh, w_trial;
    logic                   w_fits;
    logic [LEN_W:0]         w_len_sum;
    logic [LEN_W-1:0]       w_len_next;
    logic [COUNT_W-1:0]     w_count_inc;
    logic                   w_first;

    assign w_first = (r_count == '0);

    // Signed differences are one bit wider; their magnitude fits DIFF_W bits.
    assign w_dx     = $signed({i_point_x[COORD_BITS-1], i_point_x})
                    - $signed({r_prev_x[COORD_BITS-1], r_prev_x});
    assign w_dy     = $signed({i_point_y[COORD_BITS-1], i_point_y})
                    - $signed({r_prev_y[COORD_BITS-1], r_prev_y});
    assign w_abs_dx = w_dx[DIFF_W] ? DIFF_W'(-w_dx) : w_dx[DIFF_W-1:0];
    assign w_abs_dy = w_dy[DIFF_W] ? DIFF_W'(-w_dy) : w_dy[DIFF_W-1:0];

    // The single multiplier squares dx and dy on successive cycles.
    assign w_mul_a = i_cmd.square_x ? r_dx : r_dy;
    assign w_mul_p = w_mul_a * w_mul_a;

    // Restoring square root: bring down the next bit pair, try (root*4 + 1).
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fits   = (w_rem_sh >= w_trial);

    assign w_len_sum   = {1'b0, r_len} + (LEN_W + 1)'(r_root);
    assign w_len_next  = w_len_sum[LEN_W] ? LEN_MAX : w_len_sum[LEN_W-1:0];
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= i_point_x;
            r_y    <= i_point_y;
            r_last <= i_last_vertex;
            r_dx   <= w_abs_dx;
            r_dy   <= w_abs_dy;
        end
        if (i_cmd.square_x) begin
            r_sq_x <= w_mul_p;
        end
        if (i_cmd.square_y) begin
            r_sq_y <= w_mul_p;
        end
        if (i_cmd.load_radicand) begin
            r_rad  <= RAD_W'(r_sq_x) + RAD_W'(r_sq_y);
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_fits) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish && r_last) begin
            r_out_len    <= r_len;
            r_out_closed <= w_first || ((r_first_x == r_x) && (r_first_y == r_y));
            r_out_count  <= w_count_inc;
            r_out_sat    <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_sat     <= 1'b0;
        end else if (i_cmd.accumulate) begin
            r_len <= w_len_next;
            if (w_len_next == LEN_MAX) begin
                r_sat <= 1'b1;
            end
        end else if (i_cmd.finish) begin
            if (r_last) begin
                r_first_x <= '0;
                r_first_y <= '0;
                r_prev_x  <= '0;
                r_prev_y  <= '0;
                r_len     <= '0;
                r_count   <= '0;
                r_sat     <= 1'b0;
            end else begin
                if (w_first) begin
                    r_first_x <= r_x;
                    r_first_y <= r_y;
                end
                r_prev_x <= r_x;
                r_prev_y <= r_y;
                r_count  <= w_count_inc;
            end
        end
    end

    assign o_sts.first_vertex = w_first;
    assign o_sts.last_vertex  = r_last;

    assign o_total_length     = r_out_len;
    assign o_is_closed        = r_out_closed;
    assign o_vertex_count     = r_out_count;
    assign o_length_saturated = r_out_sat;

endmodule

// ===== src/polyline_length_and_closure.sv =====
`timescale 1ns / 1ps
// ============================================================================
// polyline_length_and_closure: polyline length and closure detector
// Streams polyline vertices in, emits one summary transaction per polyline.
// ============================================================================
// Vertices arrive one per transaction as signed Q12.4 coordinates, with tlast
// on the final vertex; the block takes no new vertex until it is done with
// the last. The first vertex of a polyline is only stored. For every later
// vertex the absolute differences are formed on acceptance, one shared
// 16x16 multiplier squares dx and dy in turn, and the floor square root
// of the 34-bit sum of squares is found one bit per cycle, which sets the
// rate; one step then adds the segment into the saturating Q28.4 length
// and a last one updates the vertex state. On the final vertex the
// summary (length, closed flag, vertex count and saturation flag) is loaded
// into an output register and the state is cleared, so the next polyline
// can start while the summary waits to be taken; a final vertex only holds
// in its last step if the previous summary is still unclaimed.
// A one-vertex polyline reports length zero and closed. The vertex count
// saturates at 65535 and the length at all ones, which also sets the
// saturation flag.
// ============================================================================
module polyline_length_and_closure (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Vertex input.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: point_x[15:0], point_y[31:16].
    input  logic [plg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Marks the final vertex of a polyline (last_vertex).
    input  logic                             s_axis_tlast,
    // Summary output.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0 up: total_length[31:0], is_closed[32],
    // vertex_count[48:33], length_saturated[49], zeros[55:50].
    output logic [plg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import plg_pkg::*;

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    t_coord              w_point_x, w_point_y;
    logic [LEN_W-1:0]    w_total_length;
    logic                w_is_closed;
    logic [COUNT_W-1:0]  w_vertex_count;
    logic                w_length_saturated;

    assign w_point_x = s_axis_tdata[COORD_BITS-1:0];
    assign w_point_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    plg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    plg_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_point_x          (w_point_x),
        .i_point_y          (w_point_y),
        .i_last_vertex      (s_axis_tlast),
        .o_total_length     (w_total_length),
        .o_is_closed        (w_is_closed),
        .o_vertex_count     (w_vertex_count),
        .o_length_saturated (w_length_saturated)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_length_saturated, w_vertex_count,
                           w_is_closed, w_total_length};

endmodule

// ===== src/plg_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plg_checker: port-level checks of the polyline length block
// Watches the stream ports of the top level and flags summaries that cannot
// come from a correct design.
// ============================================================================
module plg_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [plg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [plg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import plg_pkg::*;

    // A summary that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("summary changed or dropped while stalled");

    // Each vertex is worked on alone, so ready drops right after a transaction.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a vertex is still in work");

    // Every polyline has at least one vertex.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[LEN_W+COUNT_W:LEN_W+1] != '0)
        else $error("summary with zero vertices");

    // A single vertex has no length and is closed by definition.
    a_single_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[LEN_W+COUNT_W:LEN_W+1] == COUNT_W'(1))
        |-> (m_axis_tdata[LEN_W-1:0] == '0) && m_axis_tdata[LEN_W])
        else $error("one-vertex polyline with length or open flag");

    // The length sticks at all ones once reached, so flag and value agree.
    a_sat_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid
        |-> m_axis_tdata[LEN_W+COUNT_W+1] == (m_axis_tdata[LEN_W-1:0] == LEN_MAX))
        else $error("saturation flag disagrees with the length");

endmodule

bind polyline_length_and_closure plg_checker u_plg_checker (.*);

// ===== test/polyline_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// polyline_checker: summary predictor and comparator for the polyline block
// Watches the vertex and summary channels, predicts each polyline summary
// from the accepted vertices and compares it field by field on acceptance.
// ============================================================================
module polyline_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // Fields from bit 0 up: point_x[15:0], point_y[31:16].
    input  logic [plg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: total_length[31:0], is_closed[32],
    // vertex_count[48:33], length_saturated[49], zeros[55:50].
    input  logic [plg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import plg_pkg::*;

    // Expected summaries waiting for the block; the block stalls its input
    // long before this many could pile up.
    localparam int RING_DEPTH = 16;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic               closed;
        logic [COUNT_W-1:0] count;
        logic               saturated;
    } t_summary;

    // Running picture of the polyline under construction.
    t_coord             first_x, first_y, prev_x, prev_y;
    logic [LEN_W-1:0]   length_acc;
    logic [COUNT_W-1:0] vertex_tally;
    logic               sat_seen;

    t_summary expect_ring [RING_DEPTH];
    int       ring_head      = 0;
    int       ring_tail      = 0;
    int       ring_fill      = 0;
    int       summaries_seen = 0;
    int       fail_total     = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = ring_fill;

    task automatic note_failure(input string msg);
        $display("[%0t] polyline_checker: %s", $realtime, msg);
        fail_total++;
    endtask

    // Floor square root, one result bit per pass over bit pairs.
    function automatic logic [63:0] floor_root(input logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = radicand;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    task automatic clear_polyline();
        first_x      = '0;
        first_y      = '0;
        prev_x       = '0;
        prev_y       = '0;
        length_acc   = '0;
        vertex_tally = '0;
        sat_seen     = 1'b0;
    endtask

    task automatic enqueue_summary(input t_summary summary);
        if (ring_fill == RING_DEPTH) begin
            note_failure("too many summaries outstanding");
            return;
        end
        expect_ring[ring_tail] = summary;
        ring_tail = (ring_tail + 1) % RING_DEPTH;
        ring_fill++;
    endtask

    // Fold one accepted vertex into the running state; a final vertex
    // queues the summary the block should produce.
    task automatic absorb_vertex(input t_coord x, input t_coord y, input logic last);
        int            dx, dy;
        logic [63:0]   seg;
        logic [LEN_W:0] total;
        t_summary      summary;
        if (vertex_tally == 0) begin
            first_x = x;
            first_y = y;
        end else begin
            dx = int'(prev_x) - int'(x);
            dy = int'(prev_y) - int'(y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            seg   = floor_root(64'(dx) * 64'(dx) + 64'(dy) * 64'(dy));
            total = {1'b0, length_acc} + (LEN_W + 1)'(seg);
            if (total > {1'b0, LEN_MAX}) total = {1'b0, LEN_MAX};
            length_acc = total[LEN_W-1:0];
            if (length_acc == LEN_MAX) sat_seen = 1'b1;
        end
        prev_x = x;
        prev_y = y;
        if (vertex_tally != COUNT_MAX) vertex_tally++;
        if (last) begin
            summary.length    = length_acc;
            summary.closed    = (first_x == x) && (first_y == y);
            summary.count     = vertex_tally;
            summary.saturated = sat_seen;
            enqueue_summary(summary);
            clear_polyline();
        end
    endtask

    task automatic compare_summary(input logic [OUT_TDATA_W-1:0] data);
        t_summary want;
        logic [LEN_W-1:0]   got_length;
        logic               got_closed;
        logic [COUNT_W-1:0] got_count;
        logic               got_sat;
        got_length = data[LEN_W-1:0];
        got_closed = data[LEN_W];
        got_count  = data[LEN_W+1 +: COUNT_W];
        got_sat    = data[LEN_W+1+COUNT_W];
        summaries_seen++;
        if (ring_fill == 0) begin
            note_failure($sformatf("summary #%0d arrived with none expected (data %h)",
                                   summaries_seen, data));
            return;
        end
        want      = expect_ring[ring_head];
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
        if (got_length !== want.length)
            note_failure($sformatf("summary #%0d total_length: expected %0d, got %0d",
                                   summaries_seen, want.length, got_length));
        if (got_closed !== want.closed)
            note_failure($sformatf("summary #%0d is_closed: expected %0b, got %0b",
                                   summaries_seen, want.closed, got_closed));
        if (got_count !== want.count)
            note_failure($sformatf("summary #%0d vertex_count: expected %0d, got %0d",
                                   summaries_seen, want.count, got_count));
        if (got_sat !== want.saturated)
            note_failure($sformatf("summary #%0d length_saturated: expected %0b, got %0b",
                                   summaries_seen, want.saturated, got_sat));
        if (data[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
            note_failure($sformatf("summary #%0d padding bits not zero: %b",
                                   summaries_seen, data[OUT_TDATA_W-1:OUT_FIELDS_W]));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_polyline();
            ring_head = 0;
            ring_tail = 0;
            ring_fill = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) compare_summary(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                absorb_vertex(t_coord'(s_axis_tdata[COORD_BITS-1:0]),
                              t_coord'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
                              s_axis_tlast);
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for the polyline length block
// Feeds directed and random polylines with random gaps and back-pressure,
// and relies on polyline_checker to predict and compare every summary.
// ============================================================================
module testbench;
    import plg_pkg::*;

    // The limit leaves a wide margin over the slowest correct run.
    localparam int LIMIT        = 400_000;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 150;
    localparam int PRESSURE_AT  = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;

    localparam t_coord C_MIN  = 16'sh8000;
    localparam t_coord C_MAX  = 16'sh7FFF;
    localparam t_coord C_ZERO = 16'sh0000;
    localparam t_coord C_NEG1 = 16'shFFFF;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0 up: point_x[15:0], point_y[31:16].
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0 up: total_length[31:0], is_closed[32],
    // vertex_count[48:33], length_saturated[49], zeros[55:50].
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;

    // When set, neither side inserts idle cycles.
    bit calm         = 1'b0;
    // Asks the summary receiver for its one long hold-off.
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    polyline_length_and_closure dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    polyline_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Summary receiver. It stalls at random unless the run is calm, and once
    // it holds tready low for a long stretch so that the output register
    // stays full and the block has to stall its vertex input.
    initial begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    // Offer one vertex and return in the time step of the edge that accepts
    // the transaction. Random idle cycles go ahead of the offer.
    task automatic send_vertex(input t_coord x, input t_coord y, input logic last);
        if (!calm) begin
            while ($urandom_range(99) < 16) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_coord pick_extreme();
        case ($urandom_range(3))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return C_ZERO;
            default: return C_NEG1;
        endcase
    endfunction

    initial begin : stimulus
        int     sent;
        int     nverts;
        int     style;
        int     k;
        bit     closing;
        bit     pressure_done;
        t_coord fx, fy, x, y;

        sent          = 0;
        pressure_done = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-vertex polylines at both corners and at (0, -1): zero length, closed.
        send_vertex(C_MIN, C_MIN, 1'b1);
        send_vertex(C_MAX, C_MAX, 1'b1);
        send_vertex(C_ZERO, C_NEG1, 1'b1);
        // The longest single segment, corner to corner on both diagonals.
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b1);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        // A closed triangle whose segment roots are all exact.
        send_vertex(C_ZERO, C_ZERO, 1'b0);
        send_vertex(16'sd48, C_ZERO, 1'b0);
        send_vertex(C_ZERO, 16'sd64, 1'b0);
        send_vertex(C_ZERO, C_ZERO, 1'b1);
        // Repeated vertex: zero-length segment, closed.
        send_vertex(16'sd5, -16'sd7, 1'b0);
        send_vertex(16'sd5, -16'sd7, 1'b1);
        // Same x, other y: open.
        send_vertex(16'sd100, 16'sd200, 1'b0);
        send_vertex(16'sd100, -16'sd200, 1'b1);
        // Same y, other x, and a sign crossing of one LSB.
        send_vertex(C_NEG1, C_ZERO, 1'b0);
        send_vertex(16'sd1, C_ZERO, 1'b0);
        send_vertex(C_NEG1, C_ZERO, 1'b1);

        // Random polylines. The first stretch runs without idling; later the
        // receiver's long hold-off is requested while short polylines keep
        // arriving.
        while (sent < RANDOM_ITEMS) begin
            calm = (sent < CALM_ITEMS);
            if (!pressure_done && sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_request  = 1'b1;
                for (k = 0; k < 6; k++) begin
                    send_vertex(t_coord'($urandom), t_coord'($urandom), 1'b1);
                    sent++;
                end
                continue;
            end

            k = $urandom_range(99);
            if (k < 10)      nverts = 1;
            else if (k < 80) nverts = $urandom_range(2, 6);
            else             nverts = $urandom_range(7, 20);
            style   = $urandom_range(2);
            closing = (nverts >= 2) && ($urandom_range(99) < 30);

            case (style)
                0: begin
                    fx = t_coord'($urandom);
                    fy = t_coord'($urandom);
                end
                1: begin
                    fx = pick_extreme();
                    fy = pick_extreme();
                end
                default: begin
                    fx = t_coord'($urandom_range(16'hFFFF));
                    fy = t_coord'($urandom_range(16'hFFFF));
                end
            endcase
            x = fx;
            y = fy;
            for (k = 0; k < nverts; k++) begin
                if (k > 0) begin
                    if (closing && k == nverts - 1) begin
                        x = fx;
                        y = fy;
                    end else if (style == 0) begin
                        x = t_coord'($urandom);
                        y = t_coord'($urandom);
                    end else if (style == 1) begin
                        x = pick_extreme();
                        y = pick_extreme();
                    end else begin
                        // Short walk; wrapping around the coordinate range
                        // is allowed and gives the occasional long jump.
                        x = x + t_coord'($urandom_range(512) - 256);
                        y = y + t_coord'($urandom_range(512) - 256);
                    end
                end
                send_vertex(x, y, k == nverts - 1);
                sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
